>>> hw/rtl/qvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg: shared types for the quaternion vector rotation pipeline
// Component naming for quaternion parts, used to index the product arrays.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Quaternion component order: scalar first, then the vector part.
  typedef enum logic [1:0] {
    COMP_W = 2'd0,
    COMP_X = 2'd1,
    COMP_Y = 2'd2,
    COMP_Z = 2'd3
  } comp_t;

  localparam int unsigned NUM_COMP = 4;

endpackage

`default_nettype wire

>>> hw/rtl/qvr_first_product.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_first_product: t = q * (1.0, v), two register stages
// Stage A registers the sixteen signed product terms, stage B sums and rounds.
// ----------------------------------------------------------------------------
module qvr_first_product #(
  parameter int unsigned QUAT_WIDTH = 16,
  parameter int unsigned VEC_WIDTH  = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           up_valid,
  output logic                          up_ready,
  input  wire  signed [QUAT_WIDTH-1:0]  up_quat [qvr_pkg::NUM_COMP],
  input  wire  signed [VEC_WIDTH-1:0]   up_vec_x,
  input  wire  signed [VEC_WIDTH-1:0]   up_vec_y,
  input  wire  signed [VEC_WIDTH-1:0]   up_vec_z,
  output logic                          dn_valid,
  input  wire                           dn_ready,
  output logic signed [VEC_WIDTH+3:0]   dn_t [qvr_pkg::NUM_COMP],
  output logic signed [QUAT_WIDTH-1:0]  dn_quat [qvr_pkg::NUM_COMP]
);

  localparam int unsigned QF  = QUAT_WIDTH - 2;
  localparam int unsigned VF  = VEC_WIDTH / 2;
  localparam int unsigned P1W = QUAT_WIDTH + VEC_WIDTH;
  localparam int unsigned S1W = P1W + 2;
  localparam int unsigned TW  = VEC_WIDTH + 4;
  localparam logic signed [S1W-1:0] RND = S1W'(1) <<< (QF - 1);

  logic signed [P1W-1:0]        prd_nxt [qvr_pkg::NUM_COMP][qvr_pkg::NUM_COMP];
  logic signed [P1W-1:0]        prd_r   [qvr_pkg::NUM_COMP][qvr_pkg::NUM_COMP];
  logic signed [QUAT_WIDTH-1:0] a_quat_r [qvr_pkg::NUM_COMP];
  logic                         a_vld_r;
  logic signed [S1W-1:0]        sum_nxt [qvr_pkg::NUM_COMP];
  logic signed [TW-1:0]         t_nxt   [qvr_pkg::NUM_COMP];
  logic signed [TW-1:0]         t_r     [qvr_pkg::NUM_COMP];
  logic signed [QUAT_WIDTH-1:0] b_quat_r [qvr_pkg::NUM_COMP];
  logic                         b_vld_r;
  logic                         en_a;
  logic                         en_b;

  assign en_b     = !b_vld_r || dn_ready;
  assign en_a     = !a_vld_r || en_b;
  assign up_ready = en_a;

  // Stage A: product terms, indexed [result component][quaternion part].
  // The scalar 1.0 of the lifted vector turns its terms into shifts.
  always_comb begin
    logic signed [P1W-1:0] qw, qx, qy, qz, vx, vy, vz;
    qw = P1W'(up_quat[qvr_pkg::COMP_W]);
    qx = P1W'(up_quat[qvr_pkg::COMP_X]);
    qy = P1W'(up_quat[qvr_pkg::COMP_Y]);
    qz = P1W'(up_quat[qvr_pkg::COMP_Z]);
    vx = P1W'(up_vec_x);
    vy = P1W'(up_vec_y);
    vz = P1W'(up_vec_z);
    prd_nxt[qvr_pkg::COMP_W][qvr_pkg::COMP_W] = qw <<< VF;
    prd_nxt[qvr_pkg::COMP_W][qvr_pkg::COMP_X] = qx * vx;
    prd_nxt[qvr_pkg::COMP_W][qvr_pkg::COMP_Y] = qy * vy;
    prd_nxt[qvr_pkg::COMP_W][qvr_pkg::COMP_Z] = qz * vz;
    prd_nxt[qvr_pkg::COMP_X][qvr_pkg::COMP_W] = qw * vx;
    prd_nxt[qvr_pkg::COMP_X][qvr_pkg::COMP_X] = qx <<< VF;
    prd_nxt[qvr_pkg::COMP_X][qvr_pkg::COMP_Y] = qy * vz;
    prd_nxt[qvr_pkg::COMP_X][qvr_pkg::COMP_Z] = qz * vy;
    prd_nxt[qvr_pkg::COMP_Y][qvr_pkg::COMP_W] = qw * vy;
    prd_nxt[qvr_pkg::COMP_Y][qvr_pkg::COMP_X] = qx * vz;
    prd_nxt[qvr_pkg::COMP_Y][qvr_pkg::COMP_Y] = qy <<< VF;
    prd_nxt[qvr_pkg::COMP_Y][qvr_pkg::COMP_Z] = qz * vx;
    prd_nxt[qvr_pkg::COMP_Z][qvr_pkg::COMP_W] = qw * vz;
    prd_nxt[qvr_pkg::COMP_Z][qvr_pkg::COMP_X] = qx * vy;
    prd_nxt[qvr_pkg::COMP_Z][qvr_pkg::COMP_Y] = qy * vx;
    prd_nxt[qvr_pkg::COMP_Z][qvr_pkg::COMP_Z] = qz <<< VF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en_a) begin
      a_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      prd_r    <= prd_nxt;
      a_quat_r <= up_quat;
    end
  end

  // Stage B: Hamilton signs, round half up, drop fraction bits.
  always_comb begin
    sum_nxt[qvr_pkg::COMP_W] = S1W'(prd_r[qvr_pkg::COMP_W][qvr_pkg::COMP_W])
                             - S1W'(prd_r[qvr_pkg::COMP_W][qvr_pkg::COMP_X])
                             - S1W'(prd_r[qvr_pkg::COMP_W][qvr_pkg::COMP_Y])
                             - S1W'(prd_r[qvr_pkg::COMP_W][qvr_pkg::COMP_Z]);
    sum_nxt[qvr_pkg::COMP_X] = S1W'(prd_r[qvr_pkg::COMP_X][qvr_pkg::COMP_W])
                             + S1W'(prd_r[qvr_pkg::COMP_X][qvr_pkg::COMP_X])
                             + S1W'(prd_r[qvr_pkg::COMP_X][qvr_pkg::COMP_Y])
                             - S1W'(prd_r[qvr_pkg::COMP_X][qvr_pkg::COMP_Z]);
    sum_nxt[qvr_pkg::COMP_Y] = S1W'(prd_r[qvr_pkg::COMP_Y][qvr_pkg::COMP_W])
                             - S1W'(prd_r[qvr_pkg::COMP_Y][qvr_pkg::COMP_X])
                             + S1W'(prd_r[qvr_pkg::COMP_Y][qvr_pkg::COMP_Y])
                             + S1W'(prd_r[qvr_pkg::COMP_Y][qvr_pkg::COMP_Z]);
    sum_nxt[qvr_pkg::COMP_Z] = S1W'(prd_r[qvr_pkg::COMP_Z][qvr_pkg::COMP_W])
                             + S1W'(prd_r[qvr_pkg::COMP_Z][qvr_pkg::COMP_X])
                             - S1W'(prd_r[qvr_pkg::COMP_Z][qvr_pkg::COMP_Y])
                             + S1W'(prd_r[qvr_pkg::COMP_Z][qvr_pkg::COMP_Z]);
    for (int k = 0; k < qvr_pkg::NUM_COMP; k++) begin
      t_nxt[k] = TW'((sum_nxt[k] + RND) >>> QF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en_b) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_vld_r) begin
      t_r      <= t_nxt;
      b_quat_r <= a_quat_r;
    end
  end

  assign dn_valid = b_vld_r;
  assign dn_t     = t_r;
  assign dn_quat  = b_quat_r;

endmodule

`default_nettype wire

>>> hw/rtl/qvr_second_product.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_second_product: r = t * conj(q), vector part, two register stages
// Stage C registers twelve product terms, stage D sums, rounds, saturates.
// ----------------------------------------------------------------------------
module qvr_second_product #(
  parameter int unsigned QUAT_WIDTH = 16,
  parameter int unsigned VEC_WIDTH  = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           up_valid,
  output logic                          up_ready,
  input  wire  signed [VEC_WIDTH+3:0]   up_t [qvr_pkg::NUM_COMP],
  input  wire  signed [QUAT_WIDTH-1:0]  up_quat [qvr_pkg::NUM_COMP],
  output logic                          dn_valid,
  input  wire                           dn_ready,
  output logic signed [VEC_WIDTH-1:0]   dn_rot_x,
  output logic signed [VEC_WIDTH-1:0]   dn_rot_y,
  output logic signed [VEC_WIDTH-1:0]   dn_rot_z
);

  localparam int unsigned QF  = QUAT_WIDTH - 2;
  localparam int unsigned TW  = VEC_WIDTH + 4;
  localparam int unsigned P2W = TW + QUAT_WIDTH;
  localparam int unsigned S2W = P2W + 2;
  localparam int unsigned RW  = S2W - QF;
  localparam logic signed [S2W-1:0] RND    = S2W'(1) <<< (QF - 1);
  localparam logic signed [RW-1:0]  SAT_HI = RW'({1'b0, {(VEC_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0]  SAT_LO = -SAT_HI - RW'(1);

  // Terms indexed by the t component they multiply.
  logic signed [P2W-1:0]       prx_nxt [qvr_pkg::NUM_COMP];
  logic signed [P2W-1:0]       pry_nxt [qvr_pkg::NUM_COMP];
  logic signed [P2W-1:0]       prz_nxt [qvr_pkg::NUM_COMP];
  logic signed [P2W-1:0]       prx_r   [qvr_pkg::NUM_COMP];
  logic signed [P2W-1:0]       pry_r   [qvr_pkg::NUM_COMP];
  logic signed [P2W-1:0]       prz_r   [qvr_pkg::NUM_COMP];
  logic                        c_vld_r;
  logic signed [RW-1:0]        rx_full;
  logic signed [RW-1:0]        ry_full;
  logic signed [RW-1:0]        rz_full;
  logic signed [VEC_WIDTH-1:0] rot_x_nxt;
  logic signed [VEC_WIDTH-1:0] rot_y_nxt;
  logic signed [VEC_WIDTH-1:0] rot_z_nxt;
  logic signed [VEC_WIDTH-1:0] rot_x_r;
  logic signed [VEC_WIDTH-1:0] rot_y_r;
  logic signed [VEC_WIDTH-1:0] rot_z_r;
  logic                        d_vld_r;
  logic                        en_c;
  logic                        en_d;

  function automatic logic signed [VEC_WIDTH-1:0] sat_vec(input logic signed [RW-1:0] v);
    logic signed [VEC_WIDTH-1:0] res;
    priority if (v > SAT_HI) begin
      res = VEC_WIDTH'(SAT_HI);
    end else if (v < SAT_LO) begin
      res = VEC_WIDTH'(SAT_LO);
    end else begin
      res = VEC_WIDTH'(v);
    end
    return res;
  endfunction

  assign en_d     = !d_vld_r || dn_ready;
  assign en_c     = !c_vld_r || en_d;
  assign up_ready = en_c;

  // Stage C: only the vector part of the final product is needed.
  always_comb begin
    logic signed [P2W-1:0] t0, t1, t2, t3, qw, qx, qy, qz;
    t0 = P2W'(up_t[qvr_pkg::COMP_W]);
    t1 = P2W'(up_t[qvr_pkg::COMP_X]);
    t2 = P2W'(up_t[qvr_pkg::COMP_Y]);
    t3 = P2W'(up_t[qvr_pkg::COMP_Z]);
    qw = P2W'(up_quat[qvr_pkg::COMP_W]);
    qx = P2W'(up_quat[qvr_pkg::COMP_X]);
    qy = P2W'(up_quat[qvr_pkg::COMP_Y]);
    qz = P2W'(up_quat[qvr_pkg::COMP_Z]);
    prx_nxt[qvr_pkg::COMP_W] = t0 * qx;
    prx_nxt[qvr_pkg::COMP_X] = t1 * qw;
    prx_nxt[qvr_pkg::COMP_Y] = t2 * qz;
    prx_nxt[qvr_pkg::COMP_Z] = t3 * qy;
    pry_nxt[qvr_pkg::COMP_W] = t0 * qy;
    pry_nxt[qvr_pkg::COMP_X] = t1 * qz;
    pry_nxt[qvr_pkg::COMP_Y] = t2 * qw;
    pry_nxt[qvr_pkg::COMP_Z] = t3 * qx;
    prz_nxt[qvr_pkg::COMP_W] = t0 * qz;
    prz_nxt[qvr_pkg::COMP_X] = t1 * qy;
    prz_nxt[qvr_pkg::COMP_Y] = t2 * qx;
    prz_nxt[qvr_pkg::COMP_Z] = t3 * qw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en_c) begin
      c_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && up_valid) begin
      prx_r <= prx_nxt;
      pry_r <= pry_nxt;
      prz_r <= prz_nxt;
    end
  end

  // Stage D: conjugate signs folded in here.
  always_comb begin
    logic signed [S2W-1:0] sx, sy, sz;
    sx = - S2W'(prx_r[qvr_pkg::COMP_W]) + S2W'(prx_r[qvr_pkg::COMP_X])
         - S2W'(prx_r[qvr_pkg::COMP_Y]) + S2W'(prx_r[qvr_pkg::COMP_Z]);
    sy = - S2W'(pry_r[qvr_pkg::COMP_W]) + S2W'(pry_r[qvr_pkg::COMP_X])
         + S2W'(pry_r[qvr_pkg::COMP_Y]) - S2W'(pry_r[qvr_pkg::COMP_Z]);
    sz = - S2W'(prz_r[qvr_pkg::COMP_W]) - S2W'(prz_r[qvr_pkg::COMP_X])
         + S2W'(prz_r[qvr_pkg::COMP_Y]) + S2W'(prz_r[qvr_pkg::COMP_Z]);
    rx_full   = RW'((sx + RND) >>> QF);
    ry_full   = RW'((sy + RND) >>> QF);
    rz_full   = RW'((sz + RND) >>> QF);
    rot_x_nxt = sat_vec(rx_full);
    rot_y_nxt = sat_vec(ry_full);
    rot_z_nxt = sat_vec(rz_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en_d) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_vld_r) begin
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      rot_z_r <= rot_z_nxt;
    end
  end

  assign dn_valid = d_vld_r;
  assign dn_rot_x = rot_x_r;
  assign dn_rot_y = rot_y_r;
  assign dn_rot_z = rot_z_r;

endmodule

`default_nettype wire

>>> hw/rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a Q16.16 3-vector by a Q2.14 quaternion
//
// Computes the vector part of q * (1.0, v) * conj(q), each Hamilton product
// rounded half up back to the vector format, outputs saturated to VEC_WIDTH.
// No normalization: a non-unit q scales the result.
//
// Channels: in_* carries one beat per rotation (q and v), out_* one beat per
// result, both valid/ready. No configuration, no state between beats.
// Pipeline: four register stages (products, sum+round, products,
// sum+round+saturate); out_valid rises once a beat sits in the last one.
// Throughput is one beat per cycle while out_ready stays high, set by the
// fully pipelined multipliers.
// Stalls: each stage holds while the one after it is full and stalled; a
// bubble anywhere lets in_ready stay high, so the pipe keeps filling behind
// a stalled output until all four stages hold a beat.
// Reset: synchronous, active low; clears all stage valid bits, data is
// left as is.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int unsigned QUAT_WIDTH = 16,
  parameter int unsigned VEC_WIDTH  = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [QUAT_WIDTH-1:0] in_quat_w,
  input  wire  signed [QUAT_WIDTH-1:0] in_quat_x,
  input  wire  signed [QUAT_WIDTH-1:0] in_quat_y,
  input  wire  signed [QUAT_WIDTH-1:0] in_quat_z,
  input  wire  signed [VEC_WIDTH-1:0]  in_vec_x,
  input  wire  signed [VEC_WIDTH-1:0]  in_vec_y,
  input  wire  signed [VEC_WIDTH-1:0]  in_vec_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [VEC_WIDTH-1:0]  out_rot_x,
  output logic signed [VEC_WIDTH-1:0]  out_rot_y,
  output logic signed [VEC_WIDTH-1:0]  out_rot_z
);

  logic signed [QUAT_WIDTH-1:0] quat     [qvr_pkg::NUM_COMP];
  logic signed [QUAT_WIDTH-1:0] mid_quat [qvr_pkg::NUM_COMP];
  logic signed [VEC_WIDTH+3:0]  mid_t    [qvr_pkg::NUM_COMP];
  logic                         mid_valid;
  logic                         mid_ready;

  assign quat[qvr_pkg::COMP_W] = in_quat_w;
  assign quat[qvr_pkg::COMP_X] = in_quat_x;
  assign quat[qvr_pkg::COMP_Y] = in_quat_y;
  assign quat[qvr_pkg::COMP_Z] = in_quat_z;

  // t = q * (1.0, v)
  qvr_first_product #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_quat  (quat),
    .up_vec_x (in_vec_x),
    .up_vec_y (in_vec_y),
    .up_vec_z (in_vec_z),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_t     (mid_t),
    .dn_quat  (mid_quat)
  );

  // r = t * conj(q), vector part only, saturated
  qvr_second_product #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_t     (mid_t),
    .up_quat  (mid_quat),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_rot_x (out_rot_x),
    .dn_rot_y (out_rot_y),
    .dn_rot_z (out_rot_z)
  );

endmodule

`default_nettype wire

>>> sim/quaternion_vector_rotate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb: self-checking bench for the rotation pipeline
// Feeds (q, v) beats through a valid/ready driver and computes each rotated
// vector in 64-bit integer arithmetic, then compares every out beat field by
// field against the oldest outstanding prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;

  localparam int QW             = 16;
  localparam int VW             = 32;
  localparam int N_RANDOM       = 880;
  localparam int TAIL_ITEMS     = 120;   // last beats run with no idling
  localparam int PRESSURE_AT    = 300;   // results seen before the long hold
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [QW-1:0] QMAX = 16'sh7fff;
  localparam logic signed [QW-1:0] QMIN = 16'sh8000;
  localparam logic signed [VW-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [VW-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;  // 1.0 in Q2.14
  localparam logic signed [QW-1:0] Q_ZERO = 16'sd0;

  // One input beat: quaternion in Q2.14, vector in Q16.16
  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } rot_req_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } rot_vec_t;

  // Full-precision quaternion; every intermediate fits well inside 64 bits
  typedef struct packed {
    longint w;
    longint x;
    longint y;
    longint z;
  } quat64_t;

  logic     clk = 1'b1;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     out_ready = 1'b0;
  rot_req_t offer = '0;
  wire      in_ready;
  wire      out_valid;
  wire signed [VW-1:0] out_rot_x;
  wire signed [VW-1:0] out_rot_y;
  wire signed [VW-1:0] out_rot_z;

  rot_req_t req_q[$];   // beats waiting to be offered
  rot_vec_t due_q[$];   // predicted rotations, oldest first

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        pressure_done = 1'b0;
  int unsigned rx_count = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] cyc = '0;
  int unsigned mismatches = 0;

  wire beat_in  = in_valid && in_ready;
  wire beat_out = out_valid && out_ready;

  quaternion_vector_rotate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_quat_w (offer.quat_w),
    .in_quat_x (offer.quat_x),
    .in_quat_y (offer.quat_y),
    .in_quat_z (offer.quat_z),
    .in_vec_x  (offer.vec_x),
    .in_vec_y  (offer.vec_y),
    .in_vec_z  (offer.vec_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rot_x (out_rot_x),
    .out_rot_y (out_rot_y),
    .out_rot_z (out_rot_z)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Rotation predictor
  // --------------------------------------------------------------------------

  // Drop the Q2.14 scale, round half up (ties go toward +inf)
  function automatic longint round_q14(longint acc);
    return (acc + longint'(8192)) >>> 14;
  endfunction

  function automatic quat64_t hamilton(quat64_t a, quat64_t b);
    quat64_t o;
    o.w = round_q14(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
    o.x = round_q14(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
    o.y = round_q14(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
    o.z = round_q14(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
    return o;
  endfunction

  function automatic logic signed [VW-1:0] clamp_vec(longint v);
    if (v > longint'(VMAX))
      return VMAX;
    else if (v < longint'(VMIN))
      return VMIN;
    else
      return v[VW-1:0];
  endfunction

  // Vector part of q * (1.0, v) * conj(q); the scalar part is dropped
  function automatic rot_vec_t rotate_vector(rot_req_t r);
    quat64_t  q, qc, p, t, u;
    rot_vec_t o;
    q.w  = longint'($signed(r.quat_w));
    q.x  = longint'($signed(r.quat_x));
    q.y  = longint'($signed(r.quat_y));
    q.z  = longint'($signed(r.quat_z));
    qc.w = q.w;
    qc.x = -q.x;
    qc.y = -q.y;
    qc.z = -q.z;
    // lifted scalar is 1.0 in Q16.16, not zero
    p.w  = longint'(1) <<< (VW / 2);
    p.x  = longint'($signed(r.vec_x));
    p.y  = longint'($signed(r.vec_y));
    p.z  = longint'($signed(r.vec_z));
    t = hamilton(q, p);   // intermediate kept unsaturated
    u = hamilton(t, qc);
    o.x = clamp_vec(u.x);
    o.y = clamp_vec(u.y);
    o.z = clamp_vec(u.z);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic add_req(input logic signed [QW-1:0] qw, qx, qy, qz,
                         input logic signed [VW-1:0] vx, vy, vz);
    rot_req_t r;
    r.quat_w = qw;
    r.quat_x = qx;
    r.quat_y = qy;
    r.quat_z = qz;
    r.vec_x  = vx;
    r.vec_y  = vy;
    r.vec_z  = vz;
    req_q.push_back(r);
  endtask

  function automatic logic signed [VW-1:0] rand_vec(int unsigned shift);
    logic signed [VW-1:0] v;
    v = $urandom;
    return v >>> shift;
  endfunction

  // Mostly unit quaternions from a random axis and angle, with some raw
  // bit patterns and small non-unit ones mixed in.
  task automatic push_random_req();
    int       kind;
    real      th, ax, ay, az, n, s;
    rot_req_t r;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      if (kind == 9) begin
        r.quat_w = QW'(int'($urandom_range(0, 8191)) - 4096);
        r.quat_x = QW'(int'($urandom_range(0, 8191)) - 4096);
        r.quat_y = QW'(int'($urandom_range(0, 8191)) - 4096);
        r.quat_z = QW'(int'($urandom_range(0, 8191)) - 4096);
      end else begin
        th = real'($urandom_range(0, 65535)) * 6.283185307179586 / 65536.0;
        ax = real'(int'($urandom_range(0, 2000)) - 1000);
        ay = real'(int'($urandom_range(0, 2000)) - 1000);
        az = real'(int'($urandom_range(0, 2000)) - 1000);
        n  = $sqrt(ax * ax + ay * ay + az * az);
        if (n < 1.0) begin
          az = 1.0;
          n  = 1.0;
        end
        s = $sin(th / 2.0) * 16384.0 / n;
        r.quat_w = QW'($rtoi($cos(th / 2.0) * 16384.0));
        r.quat_x = QW'($rtoi(ax * s));
        r.quat_y = QW'($rtoi(ay * s));
        r.quat_z = QW'($rtoi(az * s));
      end
      // near full scale now and then, to push the outputs into saturation
      r.vec_x = rand_vec(kind >= 7 ? $urandom_range(0, 2) : $urandom_range(8, 20));
      r.vec_y = rand_vec(kind >= 7 ? $urandom_range(0, 2) : $urandom_range(8, 20));
      r.vec_z = rand_vec(kind >= 7 ? $urandom_range(0, 2) : $urandom_range(8, 20));
    end
    req_q.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued beats, holds each until taken, random gaps between
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      // offer still holds the pre-edge payload here
      if (beat_in)
        due_q.push_back(rotate_vector(offer));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          offer    <= req_q.pop_front();
          in_valid <= 1'b1;
          // gap after this beat; windows where cyc[6:5] is 2'b11 run back to back
          if (req_q.size() >= TAIL_ITEMS && cyc[6:5] != 2'b11 &&
              $urandom_range(0, 4) == 0)
            gap_left <= $urandom_range(1, 4);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: short random stalls plus one long hold-off once enough
  // results have come back, so the four-stage pipe fills and backs up into
  // in_ready while the driver keeps offering.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (!pressure_done && rx_count >= PRESSURE_AT) begin
      out_ready     <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      pressure_done <= 1'b1;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (req_q.size() >= TAIL_ITEMS && cyc[7:6] != 2'b00 &&
                 $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every out beat is matched against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name,
                             input logic signed [VW-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && beat_out) begin
      if (due_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got (%0d, %0d, %0d)",
                 $time, out_rot_x, out_rot_y, out_rot_z);
        mismatches++;
      end else begin
        check_field("rot_x", due_q[0].x, out_rot_x);
        check_field("rot_y", due_q[0].y, out_rot_y);
        check_field("rot_z", due_q[0].z, out_rot_z);
        void'(due_q.pop_front());
      end
      rx_count <= rx_count + 1;
    end
  end

  // Watchdog: a run of cycles with no beat on either side means a hang
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (beat_in || beat_out)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed beats, then random ones; reset; wait for the pipe to drain
  // --------------------------------------------------------------------------
  initial begin
    // identity rotation, ordinary and extreme vectors
    add_req(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 32'sd65536, -32'sd65536, 32'sd12345);
    add_req(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, VMAX, VMIN, 0);
    // zero quaternion collapses everything
    add_req(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, VMAX, VMIN, VMAX);
    // extreme quaternion parts against extreme vectors, saturating both ways
    add_req(QMAX, QMAX, QMAX, QMAX, VMAX, VMAX, VMAX);
    add_req(QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN);
    add_req(QMAX, QMIN, QMAX, QMIN, VMAX, VMIN, VMAX);
    add_req(QMIN, QMAX, QMIN, QMAX, VMIN, VMAX, -1);
    // quarter turn about z, half turns about x and y
    add_req(16'sd11585, Q_ZERO, Q_ZERO, 16'sd11585, 32'sd65536, 0, 0);
    add_req(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 0, 32'sd65536, 32'sd65536);
    add_req(Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, VMAX, VMAX, VMAX);
    // rounding ties: tiny q makes the low 14 bits land exactly on half
    add_req(16'sd1, Q_ZERO, Q_ZERO, Q_ZERO, 32'sd8192, -32'sd8192, 32'sd24576);
    add_req(16'sd1, Q_ZERO, Q_ZERO, Q_ZERO, -32'sd24576, 32'sd8191, -32'sd8193);
    add_req(Q_ZERO, Q_ZERO, Q_ZERO, 16'sd1, 32'sd8192, -32'sd8192, 32'sd16384);
    // negative scalar part, same rotation
    add_req(-Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 32'sd1, -32'sd1, 0);
    // non-unit q scales by |q|^2, once within range and once saturating
    add_req(QMAX, Q_ZERO, Q_ZERO, Q_ZERO, 32'sd65536, 32'sd65536, 32'sd65536);
    add_req(QMAX, Q_ZERO, Q_ZERO, Q_ZERO,
            32'sh4000_0000, -32'sh4000_0000, 32'sh2000_0000);
    add_req(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -32'sd1, -32'sd1, -32'sd1);
    add_req(16'sd11585, 16'sd11585, Q_ZERO, Q_ZERO, VMIN, VMAX, -32'sd1);
    add_req(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192,
            32'sd100000, -32'sd200000, 32'sd300000);
    repeat (N_RANDOM)
      push_random_req();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid || due_q.size() != 0)
      @(posedge clk);
    // stray beats past the last expected one still get flagged here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
